FILE: hw/rtl/cre_pkg.sv
// cre_pkg: shared types, character constants and class helper for the
// character range expander; no dependencies
package cre_pkg;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } cre_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
    } cre_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic run_multi;
        logic run_last;
        logic out_free;
    } cre_status_t;

    function automatic logic same_class_rising(input logic [7:0] a, input logic [7:0] b);
        logic lower;
        logic upper;
        logic digit;
        lower = (a >= CH_LO_A) && (a <= CH_LO_Z) && (b >= CH_LO_A) && (b <= CH_LO_Z);
        upper = (a >= CH_UP_A) && (a <= CH_UP_Z) && (b >= CH_UP_A) && (b <= CH_UP_Z);
        digit = (a >= CH_DIG_0) && (a <= CH_DIG_9) && (b >= CH_DIG_0) && (b <= CH_DIG_9);
        return (lower || upper || digit) && (a < b);
    endfunction

endpackage

FILE: hw/rtl/cre_ctrl.sv
// cre_ctrl: controller state machine for the character range expander
// depends on cre_pkg
module cre_ctrl
    import cre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  cre_status_t status,
    output cre_cmd_t    cmd
);

    cre_state_t state_reg;
    cre_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && status.out_free && status.run_multi)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.out_free && status.run_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.step   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = status.out_free;
                cmd.accept = s_tvalid && status.out_free;
            end
            ST_RUN:
            begin
                cmd.step = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cre_datapath.sv
// cre_datapath: character history, run counter and output register
// depends on cre_pkg
module cre_datapath
    import cre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_in,
    input  logic        end_of_string,
    input  cre_cmd_t    cmd,
    output cre_status_t status,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [7:0]  char_out,
    output logic        char_valid,
    output logic        last_of_run,
    output logic        string_done
);

    logic [7:0] before_reg;
    logic [7:0] held_reg;
    logic       held_valid_reg;
    logic       skip_reg;
    logic [7:0] last_sent_reg;
    logic [7:0] cnt_reg;
    logic [7:0] run_end_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_char_reg;
    logic       out_cv_reg;
    logic       out_lor_reg;
    logic       out_done_reg;

    logic [7:0] next_char;
    logic       active;
    logic       do_run;
    logic       do_single;
    logic [7:0] run_start;
    logic       run_multi;
    logic       emit_now;
    logic       out_free;

    // decode of the held character against both neighbours
    always_comb
    begin
        next_char = end_of_string ? CH_NUL : char_in;
        active    = held_valid_reg && !skip_reg;
        do_run    = active && (held_reg == CH_DASH) && same_class_rising(before_reg, next_char);
        do_single = active && !do_run
                    && ((held_reg == CH_DASH) || !((before_reg == CH_DASH) && (next_char == CH_DASH)));
        run_start = (last_sent_reg == before_reg) ? before_reg + 8'd1 : before_reg;
        run_multi = do_run && (run_start != next_char);
        emit_now  = do_run || do_single || end_of_string;
        out_free  = !out_valid_reg || out_ready;
    end

    assign status.run_multi = run_multi;
    assign status.run_last  = (cnt_reg == run_end_reg);
    assign status.out_free  = out_free;

    // string history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            before_reg     <= CH_NUL;
            held_reg       <= CH_NUL;
            held_valid_reg <= 1'b0;
            skip_reg       <= 1'b0;
            last_sent_reg  <= CH_NUL;
        end
        else if (cmd.accept)
        begin
            if (end_of_string)
            begin
                before_reg     <= CH_NUL;
                held_reg       <= CH_NUL;
                held_valid_reg <= 1'b0;
                skip_reg       <= 1'b0;
                last_sent_reg  <= CH_NUL;
            end
            else
            begin
                if (held_valid_reg)
                begin
                    before_reg <= held_reg;
                end
                held_reg       <= char_in;
                held_valid_reg <= 1'b1;
                skip_reg       <= do_run;
                if (do_run)
                begin
                    last_sent_reg <= next_char;
                end
                else if (do_single)
                begin
                    last_sent_reg <= held_reg;
                end
            end
        end
    end

    // run counter
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cnt_reg     <= run_start + 8'd1;
            run_end_reg <= next_char;
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg + 8'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((cmd.accept && emit_now) || cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept && emit_now)
        begin
            out_char_reg <= do_run ? run_start : (do_single ? held_reg : CH_NUL);
            out_cv_reg   <= do_run || do_single;
            out_lor_reg  <= !run_multi;
            out_done_reg <= end_of_string;
        end
        else if (cmd.step)
        begin
            out_char_reg <= cnt_reg;
            out_cv_reg   <= 1'b1;
            out_lor_reg  <= (cnt_reg == run_end_reg);
            out_done_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_out    = out_char_reg;
    assign char_valid  = out_cv_reg;
    assign last_of_run = out_lor_reg;
    assign string_done = out_done_reg;

endmodule

FILE: hw/rtl/char_range_expander.sv
// char_range_expander: top level of the character range expander
// depends on cre_pkg, cre_ctrl and cre_datapath
// a request's first result sits in the output register in the cycle after acceptance
// throughput: one request per cycle while each emits at most one character and the output is not stalled
// a range emitting more than one character holds s_tready low while the rest of it is stepped out
// reset (rst_n low, asynchronous) clears the history, the state machine and the output valid flag
module char_range_expander
    import cre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,   // end_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic [1:0] m_tuser,   // [0] char_valid, [1] last_of_run
    output logic       m_tlast    // string_done
);

    cre_cmd_t    cmd;
    cre_status_t status;

    // controller: takes requests when idle and the output register is free,
    // then paces the rest of a range one character per free slot
    cre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: before, held and last sent characters, range counter and
    // the output register that parts the two sides
    cre_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_in       (s_tdata),
        .end_of_string (s_tlast),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .char_out      (m_tdata),
        .char_valid    (m_tuser[0]),
        .last_of_run   (m_tuser[1]),
        .string_done   (m_tlast)
    );

endmodule

FILE: hw/rtl/cre_checker.sv
// cre_checker: port-level assertions for the character range expander
// bound to char_range_expander; no other dependencies
module cre_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // a stalled result blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
    else $error("request taken while result stalled");

    // end of string always closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1])
    else $error("string done without last of run");

    // an empty result only ends a string and carries a zero character
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == 8'h00))
    else $error("bad empty result");

    // held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind char_range_expander cre_checker u_cre_checker (.*);

FILE: test/tb.sv
// tb: self-checking testbench for char_range_expander, stream requests in and results out
// depends on cre_pkg for the character constants and on the char_range_expander rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cre_pkg::*;

    // character groups that can form a range
    typedef enum int {
        GRP_NONE,
        GRP_LOWER,
        GRP_UPPER,
        GRP_DIGIT
    } grp_t;

    // one request towards the slave side
    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } req_t;

    // one expected result on the master side
    typedef struct {
        logic [7:0] ch;
        logic       ch_ok;
        logic       run_end;
        logic       done;
    } res_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;    // [7:0] char_in
    logic       s_tlast = 1'b0;     // end_of_string
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] char_out
    logic [1:0] m_tuser;            // [0] char_valid, [1] last_of_run
    logic       m_tlast;            // string_done

    // requests still to be sent and results still to come
    req_t req_pending[$];
    res_t res_expected[$];

    // shadow of the expander history
    logic [7:0] left_ch;
    logic [7:0] held_ch;
    logic       held_ok;
    logic       held_eaten;
    logic [7:0] last_out;

    // result being built; its flags are only known once the request is fully expanded
    res_t tail;
    bit   have_tail;
    int   n_this_req;

    // sender burst and receiver stall bookkeeping
    req_t       nxt;
    int         burst_left = 1;
    int         gap_left = 0;
    logic [7:0] ready_pat = 8'hFF;
    int         pat_left = 0;

    // run statistics
    int n_items;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_strings = 0;
    int n_ranges = 0;
    int n_widest = 0;

    char_range_expander DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1ns clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic grp_t grp_of(input logic [7:0] c);
        if (c >= CH_LO_A && c <= CH_LO_Z)
            return GRP_LOWER;
        if (c >= CH_UP_A && c <= CH_UP_Z)
            return GRP_UPPER;
        if (c >= CH_DIG_0 && c <= CH_DIG_9)
            return GRP_DIGIT;
        return GRP_NONE;
    endfunction

    function automatic void grp_bounds(input grp_t g, output logic [7:0] lo,
                                       output logic [7:0] hi);
        unique case (g)
            GRP_LOWER:
            begin
                lo = CH_LO_A;
                hi = CH_LO_Z;
            end
            GRP_UPPER:
            begin
                lo = CH_UP_A;
                hi = CH_UP_Z;
            end
            default:
            begin
                lo = CH_DIG_0;
                hi = CH_DIG_9;
            end
        endcase
    endfunction

    // a dash between these two opens a range
    function automatic bit opens_range(input logic [7:0] a, input logic [7:0] b);
        return grp_of(a) != GRP_NONE && grp_of(a) == grp_of(b) && a < b;
    endfunction

    // queue one character; the previous one is now known not to close the request
    function automatic void emit_char(input logic [7:0] c);
        if (have_tail)
            res_expected.push_back(tail);
        tail = '{ch: c, ch_ok: 1'b1, run_end: 1'b0, done: 1'b0};
        have_tail = 1'b1;
        last_out = c;
        n_this_req++;
    endfunction

    function automatic void clear_history();
        left_ch = CH_NUL;
        held_ch = CH_NUL;
        held_ok = 1'b0;
        held_eaten = 1'b0;
        last_out = CH_NUL;
    endfunction

    // works out every result caused by one accepted request
    function automatic void expand_request(input logic [7:0] c, input logic fin);
        logic [7:0] right_ch;
        bit         took;
        int         k;
        right_ch = fin ? CH_NUL : c;
        took = 1'b0;
        have_tail = 1'b0;
        n_this_req = 0;
        if (held_ok && !held_eaten)
        begin
            if (held_ch == CH_DASH)
            begin
                if (opens_range(left_ch, right_ch))
                begin
                    // skip the opening character if it has just gone out
                    k = (last_out == left_ch) ? int'(left_ch) + 1 : int'(left_ch);
                    for (; k <= int'(right_ch); k++)
                        emit_char(k[7:0]);
                    took = 1'b1;
                    n_ranges++;
                end
                else
                    emit_char(held_ch);
            end
            else if (!(left_ch == CH_DASH && right_ch == CH_DASH))
                emit_char(held_ch);
        end
        if (fin)
        begin
            // an end request always yields a result, even an empty one
            if (!have_tail)
            begin
                tail = '{ch: CH_NUL, ch_ok: 1'b0, run_end: 1'b0, done: 1'b0};
                n_this_req++;
            end
            tail.run_end = 1'b1;
            tail.done = 1'b1;
            res_expected.push_back(tail);
            clear_history();
            n_strings++;
        end
        else
        begin
            if (have_tail)
            begin
                tail.run_end = 1'b1;
                res_expected.push_back(tail);
            end
            if (held_ok)
                left_ch = held_ch;
            held_ch = c;
            held_ok = 1'b1;
            held_eaten = took;
        end
        if (n_this_req > n_widest)
            n_widest = n_this_req;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    function automatic void add_item(input logic [7:0] c, input logic fin);
        req_pending.push_back('{ch: c, fin: fin});
    endfunction

    function automatic void add_text(input string txt, input bit close);
        for (int i = 0; i < txt.len(); i++)
            add_item(txt[i], 1'b0);
        if (close)
            add_item(8'($urandom_range(255, 0)), 1'b1);
    endfunction

    // mostly well-formed ranges, with stray dashes, broken ranges and odd bytes mixed in
    function automatic void add_random_string();
        int         n_tok;
        int         kind;
        logic [7:0] base;
        logic [7:0] top;
        logic [7:0] a;
        logic [7:0] b;
        n_tok = $urandom_range(6, 0);
        repeat (n_tok)
        begin
            kind = $urandom_range(9, 0);
            if (kind <= 4)
            begin
                grp_bounds(grp_t'($urandom_range(3, 1)), base, top);
                a = 8'($urandom_range(top - 1, base));
                if (kind == 4)
                begin
                    // end point from any group, so reversed, equal and mixed ranges
                    grp_bounds(grp_t'($urandom_range(3, 1)), base, top);
                    b = 8'($urandom_range(top, base));
                end
                else
                    b = 8'($urandom_range(top, a + 8'd1));
                add_item(a, 1'b0);
                add_item(CH_DASH, 1'b0);
                add_item(b, 1'b0);
                // chained range sharing its end point
                if ($urandom_range(2, 0) == 0 && grp_of(b) != GRP_NONE)
                begin
                    grp_bounds(grp_of(b), base, top);
                    if (b < top)
                    begin
                        add_item(CH_DASH, 1'b0);
                        add_item(8'($urandom_range(top, b + 8'd1)), 1'b0);
                    end
                end
            end
            else if (kind == 5)
                add_item(CH_DASH, 1'b0);
            else if (kind == 6)
            begin
                add_item(CH_DASH, 1'b0);
                add_item(8'($urandom_range(255, 0)), 1'b0);
                add_item(CH_DASH, 1'b0);
            end
            else if (kind == 7)
                add_item(8'($urandom_range(255, 0)), 1'b0);
            else if (kind == 8)
            begin
                grp_bounds(grp_t'($urandom_range(3, 1)), base, top);
                add_item(8'($urandom_range(top, base)), 1'b0);
            end
            else
                add_item(CH_NUL, 1'b0);
        end
        add_item(8'($urandom_range(255, 0)), 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // sender: bursts of requests with random gaps between them
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expand_request(s_tdata, s_tlast);
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (req_pending.size() > 0)
                begin
                    nxt = req_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.ch;
                    s_tlast <= nxt.fin;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(24, 1);
                        gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: rotating stall pattern, changed every so often
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (pat_left == 0)
        begin
            // a third of the time no stalls at all
            ready_pat = ($urandom_range(2, 0) == 0) ? 8'hFF
                        : (8'($urandom_range(255, 0)) | 8'h01);
            pat_left = $urandom_range(200, 20);
        end
        else
        begin
            ready_pat = {ready_pat[0], ready_pat[7:1]};
            pat_left--;
        end
        m_tready <= ready_pat[0];
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (res_expected.size() == 0)
            begin
                $error("result with nothing expected: char_out %02h", m_tdata);
                n_errors++;
            end
            else
            begin
                want = res_expected.pop_front();
                if (m_tdata !== want.ch)
                begin
                    $error("char_out expected %02h got %02h", want.ch, m_tdata);
                    n_errors++;
                end
                if (m_tuser[0] !== want.ch_ok)
                begin
                    $error("char_valid expected %0b got %0b", want.ch_ok, m_tuser[0]);
                    n_errors++;
                end
                if (m_tuser[1] !== want.run_end)
                begin
                    $error("last_of_run expected %0b got %0b", want.run_end, m_tuser[1]);
                    n_errors++;
                end
                if (m_tlast !== want.done)
                begin
                    $error("string_done expected %0b got %0b", want.done, m_tlast);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        clear_history();

        // empty string: only the end request
        add_item(8'($urandom_range(255, 0)), 1'b1);
        // widest range
        add_text("a-z", 1'b1);
        // chained ranges, the second opening on the character just sent
        add_text("a-c-f", 1'b1);
        // leading dash, character between dashes dropped, trailing dash
        add_text("-q-", 1'b1);
        // digits, a falling range, then bytes outside every group and a zero byte
        add_text("0-9Z-A", 1'b0);
        add_item(8'h80, 1'b0);
        add_item(CH_NUL, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'($urandom_range(255, 0)), 1'b1);

        while (req_pending.size() < 450)
            add_random_string();
        n_items = req_pending.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_items)
            @(negedge clk);
        while (res_expected.size() != 0)
            @(negedge clk);
        // room for any stray result after the last expected one
        repeat (30) @(negedge clk);

        $display("summary: %0d requests in %0d strings, %0d results checked",
                 n_accepted, n_strings, n_checked);
        $display("summary: %0d ranges expanded, up to %0d results from one request",
                 n_ranges, n_widest);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #1000000ns;
        $display("tb: failure");
        $finish;
    end

endmodule
